// ===== hw/rtl/rres_pkg.sv =====
// ----------------------------------------------------------------------------
// Rumble envelope sequencer package
// Shared types, register indexes, reset values and command/status bundles.
// ----------------------------------------------------------------------------
package rres_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_FIRST_GAP   = 3'd0;
  localparam logic [2:0] CFG_FIRST_RANGE = 3'd1;
  localparam logic [2:0] CFG_GAP_MIN     = 3'd2;
  localparam logic [2:0] CFG_GAP_RANGE   = 3'd3;
  localparam logic [2:0] CFG_PERIOD_MIN  = 3'd4;
  localparam logic [2:0] CFG_PEAK_MIN    = 3'd5;
  localparam logic [2:0] CFG_RISE_RATE   = 3'd6;
  localparam logic [2:0] CFG_FALL_RATE   = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_FIRST_GAP   = 16'd200;
  localparam logic [7:0]  RST_FIRST_RANGE = 8'd100;
  localparam logic [15:0] RST_GAP_MIN     = 16'd100;
  localparam logic [7:0]  RST_GAP_RANGE   = 8'd200;
  localparam logic [11:0] RST_PERIOD_MIN  = 12'd2432;
  localparam logic [3:0]  RST_PEAK_MIN    = 4'd11;
  localparam logic [7:0]  RST_RISE_RATE   = 8'd15;
  localparam logic [7:0]  RST_FALL_RATE   = 8'd25;

  localparam logic [11:0] NOISE_BASE = 12'd28;
  localparam logic [3:0]  AMP_MAX    = 4'd15;
  localparam int unsigned MAX_WRITES = 3;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } rres_func_e;

  typedef enum logic [1:0] {
    KIND_PITCH = 2'd0,
    KIND_AMP   = 2'd1,
    KIND_MIXER = 2'd2,
    KIND_NOISE = 2'd3
  } rres_kind_e;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } rres_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DISPATCH = 2'd1,
    ST_MOD      = 2'd2,
    ST_EMIT     = 2'd3
  } rres_state_e;

  // One chip register write
  typedef struct packed {
    rres_kind_e  kind;
    logic [1:0]  channel;
    logic [11:0] value;
    logic        tone_on;
    logic        noise_on;
  } rres_wr_t;

  typedef struct packed {
    logic load;
    logic mod_start;
    logic pop;
  } rres_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic has_wr;
    logic mod_done;
    logic pop_last;
  } rres_sts_t;

endpackage

// ===== hw/rtl/random_rumble_envelope_sequencer.sv =====
// ----------------------------------------------------------------------------
// Random rumble envelope sequencer
// Turns start commands and frame ticks into sound chip register writes.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with func_i and the random operands.
//   func_i = 0 restarts the wait with the first gap, func_i = 1 is a frame tick.
// Output channel: out_valid_o / out_stall_i, one chip write per beat; last_o
//   marks the final beat of an item. A start or a quiet tick gives no beats.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//   write only while the block is idle.
// One item is handled at a time. A tick that reloads no gap is accepted,
//   dispatched and then emits one beat per cycle while out_stall_i is low. A
//   start, or the tick that ends a rumble, also runs the bit-serial remainder
//   unit for the gap spread (16 steps, then a done strobe) before any beats
//   and before the next accept.
// While out_stall_i is high the current beat holds and no new item is taken.
// Reset (rst_ni low, asynchronous) loads the register defaults, puts the
//   envelope in the waiting phase with a zero gap and drops any pending beats.
// ----------------------------------------------------------------------------
module random_rumble_envelope_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [9:0]  rand_pitch_i,
  input  logic        rand_side_i,
  input  logic [1:0]  rand_peak_i,
  input  logic [1:0]  rand_noise_i,
  input  logic [15:0] rand_gap_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  write_kind_o,
  output logic [1:0]  channel_o,
  output logic [11:0] write_value_o,
  output logic        tone_on_o,
  output logic        noise_on_o,
  output logic        last_o
);

  rres_pkg::rres_cmd_t cmd;
  rres_pkg::rres_sts_t sts;
  rres_pkg::rres_wr_t  out_wr;

  rres_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rres_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .rand_pitch_i (rand_pitch_i),
    .rand_side_i  (rand_side_i),
    .rand_peak_i  (rand_peak_i),
    .rand_noise_i (rand_noise_i),
    .rand_gap_i   (rand_gap_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_wr_o     (out_wr)
  );

  assign write_kind_o  = out_wr.kind;
  assign channel_o     = out_wr.channel;
  assign write_value_o = out_wr.value;
  assign tone_on_o     = out_wr.tone_on;
  assign noise_on_o    = out_wr.noise_on;
  assign last_o        = sts.pop_last;

endmodule

// ===== hw/rtl/rres_mod.sv =====
// ----------------------------------------------------------------------------
// Remainder unit
// Bit-serial restoring remainder of a 16-bit word by an 8-bit divisor.
// ----------------------------------------------------------------------------
module rres_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic [7:0]  rem_o,
  output logic        done_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [15:0] dvd_q, dvd_d;
  logic [7:0]  dsr_q, dsr_d;
  logic [7:0]  rem_q, rem_d;
  logic [8:0]  trial;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[15]};
    if (start_i) begin
      cnt_d = 5'd16;
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != 5'd0) begin
      // one quotient bit per cycle
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 8'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[7:0];
      end
      dvd_d  = {dvd_q[14:0], 1'b0};
      cnt_d  = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/rres_dp.sv =====
// ----------------------------------------------------------------------------
// Rumble envelope datapath
// Config registers, envelope state, gap reload and the write buffer.
// ----------------------------------------------------------------------------
module rres_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                func_i,
  input  logic [9:0]          rand_pitch_i,
  input  logic                rand_side_i,
  input  logic [1:0]          rand_peak_i,
  input  logic [1:0]          rand_noise_i,
  input  logic [15:0]         rand_gap_i,
  input  rres_pkg::rres_cmd_t cmd_i,
  output rres_pkg::rres_sts_t sts_o,
  output rres_pkg::rres_wr_t  out_wr_o
);

  // configuration
  logic [15:0] first_gap_q, gap_min_q;
  logic [7:0]  first_range_q, gap_range_q, rise_rate_q, fall_rate_q;
  logic [11:0] period_min_q;
  logic [3:0]  peak_min_q;

  // envelope state
  rres_pkg::rres_phase_e phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [1:0]  chan_q, chan_d;
  logic [3:0]  peak_q, peak_d;
  logic [3:0]  amp_q, amp_d;
  logic [7:0]  step_q, step_d;

  // beat buffer and sequencing
  rres_pkg::rres_wr_t wr_q [rres_pkg::MAX_WRITES];
  rres_pkg::rres_wr_t wr_d [rres_pkg::MAX_WRITES];
  logic [1:0]  wr_cnt_q, wr_cnt_d;
  logic [1:0]  rd_idx_q;
  logic        need_mod_q, need_mod_d;
  logic        is_first_q, is_first_d;
  logic [15:0] rgap_q;

  logic [7:0]  mod_rem;
  logic        mod_done;
  logic [7:0]  sel_range;
  logic [15:0] sel_base;
  logic [7:0]  spread;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_gap_q   <= rres_pkg::RST_FIRST_GAP;
      first_range_q <= rres_pkg::RST_FIRST_RANGE;
      gap_min_q     <= rres_pkg::RST_GAP_MIN;
      gap_range_q   <= rres_pkg::RST_GAP_RANGE;
      period_min_q  <= rres_pkg::RST_PERIOD_MIN;
      peak_min_q    <= rres_pkg::RST_PEAK_MIN;
      rise_rate_q   <= rres_pkg::RST_RISE_RATE;
      fall_rate_q   <= rres_pkg::RST_FALL_RATE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rres_pkg::CFG_FIRST_GAP:   first_gap_q   <= cfg_wdata_i;
        rres_pkg::CFG_FIRST_RANGE: first_range_q <= cfg_wdata_i[7:0];
        rres_pkg::CFG_GAP_MIN:     gap_min_q     <= cfg_wdata_i;
        rres_pkg::CFG_GAP_RANGE:   gap_range_q   <= cfg_wdata_i[7:0];
        rres_pkg::CFG_PERIOD_MIN:  period_min_q  <= cfg_wdata_i[11:0];
        rres_pkg::CFG_PEAK_MIN:    peak_min_q    <= cfg_wdata_i[3:0];
        rres_pkg::CFG_RISE_RATE:   rise_rate_q   <= cfg_wdata_i[7:0];
        rres_pkg::CFG_FALL_RATE:   fall_rate_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Item evaluation: next envelope state and the writes it causes
  always_comb begin
    logic [15:0] wc;
    logic [7:0]  sc;
    logic [4:0]  pk;
    logic [3:0]  amp_new;
    logic [1:0]  ch_new;
    phase_d    = phase_q;
    wait_d     = wait_q;
    chan_d     = chan_q;
    peak_d     = peak_q;
    amp_d      = amp_q;
    step_d     = step_q;
    need_mod_d = 1'b0;
    is_first_d = 1'b0;
    wr_cnt_d   = 2'd0;
    for (int i = 0; i < rres_pkg::MAX_WRITES; i++) begin
      wr_d[i] = '{kind: rres_pkg::KIND_PITCH, channel: 2'd0, value: 12'd0,
                  tone_on: 1'b0, noise_on: 1'b0};
    end
    wc      = wait_q - 16'd1;
    sc      = step_q - 8'd1;
    pk      = {1'b0, peak_min_q} + {3'b0, rand_peak_i};
    ch_new  = {rand_side_i, 1'b0};
    amp_new = amp_q;

    if (func_i == rres_pkg::FUNC_START) begin
      phase_d    = rres_pkg::PH_WAIT;
      need_mod_d = 1'b1;
      is_first_d = 1'b1;
    end else begin
      case (phase_q)
        rres_pkg::PH_WAIT: begin
          wait_d = wc;
          if (wc == 16'd0) begin
            chan_d  = ch_new;
            peak_d  = pk[4] ? rres_pkg::AMP_MAX : pk[3:0];
            amp_d   = 4'd0;
            step_d  = rise_rate_q;
            phase_d = rres_pkg::PH_RISE;
            wr_d[0].kind     = rres_pkg::KIND_NOISE;
            wr_d[0].value    = rres_pkg::NOISE_BASE + {10'd0, rand_noise_i};
            wr_d[1].kind     = rres_pkg::KIND_AMP;
            wr_d[1].channel  = ch_new;
            wr_d[2].kind     = rres_pkg::KIND_MIXER;
            wr_d[2].channel  = ch_new;
            wr_d[2].tone_on  = 1'b1;
            wr_d[2].noise_on = 1'b1;
            wr_cnt_d = 2'd3;
          end
        end
        rres_pkg::PH_RISE: begin
          wr_d[0].channel = chan_q;
          wr_d[0].value   = period_min_q + {2'b0, rand_pitch_i};
          wr_cnt_d = 2'd1;
          step_d   = sc;
          if (sc == 8'd0) begin
            step_d = rise_rate_q;
            if (amp_q < rres_pkg::AMP_MAX) amp_new = amp_q + 4'd1;
            amp_d = amp_new;
            wr_d[1].kind    = rres_pkg::KIND_AMP;
            wr_d[1].channel = chan_q;
            wr_d[1].value   = {8'd0, amp_new};
            wr_cnt_d = 2'd2;
            if (amp_new >= peak_q) begin
              step_d  = fall_rate_q;
              phase_d = rres_pkg::PH_FALL;
            end
          end
        end
        default: begin
          wr_d[0].channel = chan_q;
          wr_d[0].value   = period_min_q + {2'b0, rand_pitch_i};
          wr_cnt_d = 2'd1;
          step_d   = sc;
          if (sc == 8'd0) begin
            step_d = fall_rate_q;
            if (amp_q != 4'd0) amp_new = amp_q - 4'd1;
            amp_d = amp_new;
            wr_d[1].kind    = rres_pkg::KIND_AMP;
            wr_d[1].channel = chan_q;
            wr_d[1].value   = {8'd0, amp_new};
            wr_cnt_d = 2'd2;
            if (amp_new == 4'd0) begin
              wr_d[2].kind    = rres_pkg::KIND_MIXER;
              wr_d[2].channel = chan_q;
              wr_cnt_d   = 2'd3;
              need_mod_d = 1'b1;
              phase_d    = rres_pkg::PH_WAIT;
            end
          end
        end
      endcase
    end
  end

  // gap reload operands; the user must not change ranges while the block is busy (not enforced here)
  assign sel_range = is_first_q ? first_range_q : gap_range_q;
  assign sel_base  = is_first_q ? first_gap_q : gap_min_q;
  assign spread    = (sel_range == 8'd0) ? 8'd0 : mod_rem;

  rres_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (rgap_q),
    .divisor_i  (sel_range),
    .rem_o      (mod_rem),
    .done_o     (mod_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rres_pkg::PH_WAIT;
      wait_q     <= '0;
      chan_q     <= '0;
      peak_q     <= '0;
      amp_q      <= '0;
      step_q     <= '0;
      wr_cnt_q   <= '0;
      rd_idx_q   <= '0;
      need_mod_q <= 1'b0;
      is_first_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        phase_q    <= phase_d;
        wait_q     <= wait_d;
        chan_q     <= chan_d;
        peak_q     <= peak_d;
        amp_q      <= amp_d;
        step_q     <= step_d;
        wr_cnt_q   <= wr_cnt_d;
        rd_idx_q   <= '0;
        need_mod_q <= need_mod_d;
        is_first_q <= is_first_d;
      end else begin
        if (mod_done) wait_q <= sel_base + {8'd0, spread};
        if (cmd_i.pop) rd_idx_q <= rd_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rgap_q <= rand_gap_i;
      for (int i = 0; i < rres_pkg::MAX_WRITES; i++) begin
        wr_q[i] <= wr_d[i];
      end
    end
  end

  assign out_wr_o       = wr_q[rd_idx_q];
  assign sts_o.need_mod = need_mod_q;
  assign sts_o.has_wr   = (wr_cnt_q != 2'd0);
  assign sts_o.mod_done = mod_done;
  assign sts_o.pop_last = (rd_idx_q == (wr_cnt_q - 2'd1));

endmodule

// ===== hw/rtl/rres_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rumble envelope controller
// Sequences accept, gap reload and write emission for one item at a time.
// ----------------------------------------------------------------------------
module rres_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  rres_pkg::rres_sts_t sts_i,
  output rres_pkg::rres_cmd_t cmd_o
);

  rres_pkg::rres_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rres_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rres_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rres_pkg::ST_DISPATCH;
        end
      end
      rres_pkg::ST_DISPATCH: begin
        if (sts_i.need_mod) begin
          cmd_o.mod_start = 1'b1;
          state_d         = rres_pkg::ST_MOD;
        end else if (sts_i.has_wr) begin
          state_d = rres_pkg::ST_EMIT;
        end else begin
          state_d = rres_pkg::ST_IDLE;
        end
      end
      rres_pkg::ST_MOD: begin
        if (sts_i.mod_done) begin
          state_d = sts_i.has_wr ? rres_pkg::ST_EMIT : rres_pkg::ST_IDLE;
        end
      end
      rres_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          cmd_o.pop = 1'b1;
          if (sts_i.pop_last) state_d = rres_pkg::ST_IDLE;
        end
      end
      default: state_d = rres_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != rres_pkg::ST_IDLE);
  assign out_valid_o = (state_q == rres_pkg::ST_EMIT);

  a_no_accept_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while writes pending");

  a_load_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == rres_pkg::ST_DISPATCH)
    else $error("load not followed by dispatch");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mod_done |-> state_q == rres_pkg::ST_MOD)
    else $error("remainder done outside reload");

  a_last_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && sts_i.pop_last) |=> state_q == rres_pkg::ST_IDLE)
    else $error("last beat did not end item");

endmodule
